@@ design/mnh_pkg.sv @@
// ----------------------------------------------------------------------------
// mnh_pkg: shared types and constants of the MIDI note harmonizer
// Payload structs, the job descriptor passed from front to back, and the
// byte expansion of one job.
// ----------------------------------------------------------------------------
package mnh_pkg;

    localparam logic [7:0] NOTE_ON_MASK  = 8'hF0;
    localparam logic [7:0] NOTE_ON_CODE  = 8'h90;
    localparam logic [7:0] OFF_STATUS    = 8'h81;
    localparam logic [7:0] ON_STATUS     = 8'h91;
    localparam logic [7:0] HARMONY_STEP  = 8'd4;
    localparam logic [7:0] RELEASE_STEP  = 8'd7;
    localparam logic [7:0] PERIOD_RESET  = 8'd30;
    localparam logic [7:0] HARMONY_RESET = 8'd50;

    localparam int QUEUE_DEPTH = 4;

    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] PASS_LAST_IDX  = 4'd0;
    localparam logic [IDX_W-1:0] BURST_LAST_IDX = 4'd5;
    localparam logic [IDX_W-1:0] CHORD_LAST_IDX = 4'd8;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic [2:0] harmony_offset;
    } in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } out_t;

    typedef enum logic [1:0] {
        JOB_PASS,
        JOB_BURST,
        JOB_CHORD
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] status;
        logic [7:0] note;
        logic [7:0] velocity;
        logic [7:0] old_harmony;
        logic [7:0] new_harmony;
    } job_t;

    // Byte at position idx of the run that a job expands into.
    function automatic out_t job_byte(job_t j, logic [IDX_W-1:0] idx);
        out_t o;
        o.tx_byte = 8'h00;
        o.last    = 1'b0;
        case (j.kind)
            JOB_PASS:
            begin
                o.tx_byte = j.status;
                o.last    = 1'b1;
            end
            JOB_BURST:
            begin
                case (idx)
                    4'd0:    o.tx_byte = OFF_STATUS;
                    4'd1:    o.tx_byte = j.old_harmony;
                    4'd3:    o.tx_byte = OFF_STATUS;
                    4'd4:    o.tx_byte = j.old_harmony + RELEASE_STEP;
                    default: o.tx_byte = 8'h00;
                endcase
                o.last = (idx == BURST_LAST_IDX);
            end
            JOB_CHORD:
            begin
                case (idx)
                    4'd0:    o.tx_byte = j.status;
                    4'd1:    o.tx_byte = j.note;
                    4'd2:    o.tx_byte = j.velocity;
                    4'd3:    o.tx_byte = OFF_STATUS;
                    4'd4:    o.tx_byte = j.old_harmony;
                    4'd6:    o.tx_byte = ON_STATUS;
                    4'd7:    o.tx_byte = j.new_harmony;
                    4'd8:    o.tx_byte = j.velocity;
                    default: o.tx_byte = 8'h00;
                endcase
                o.last = (idx == CHORD_LAST_IDX);
            end
            default:
            begin
                o.tx_byte = j.status;
                o.last    = 1'b1;
            end
        endcase
        return o;
    endfunction

endpackage

@@ design/mnh_front.sv @@
// ----------------------------------------------------------------------------
// mnh_front: input classifier
// Tracks the capture phase, held bytes, harmony note and tick count, and
// turns each accepted beat into at most one job.
// ----------------------------------------------------------------------------
module mnh_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  mnh_pkg::in_t  item,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    output logic          job_push,
    output mnh_pkg::job_t job
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_NOTE,
        PH_VEL
    } phase_t;

    phase_t     phase_reg,   phase_next;
    logic [7:0] status_reg,  status_next;
    logic [7:0] note_reg,    note_next;
    logic [7:0] harmony_reg, harmony_next;
    logic [7:0] tick_reg,    tick_next;
    logic [7:0] period_reg,  period_next;

    always_comb
    begin
        phase_next   = phase_reg;
        status_next  = status_reg;
        note_next    = note_reg;
        harmony_next = harmony_reg;
        tick_next    = tick_reg;
        period_next  = cfg_wr_en ? cfg_wr_data : period_reg;

        job_push        = 1'b0;
        job.kind        = mnh_pkg::JOB_PASS;
        job.status      = item.rx_byte;
        job.note        = note_reg;
        job.velocity    = item.rx_byte;
        job.old_harmony = harmony_reg;
        job.new_harmony = harmony_reg;

        if (accept)
        begin
            if (item.operation == mnh_pkg::OP_TICK)
            begin
                // burst and restart the count when it has reached the period, else count on
                if (tick_reg >= period_reg)
                begin
                    job_push  = 1'b1;
                    job.kind  = mnh_pkg::JOB_BURST;
                    tick_next = 8'd1;
                end
                else
                begin
                    tick_next = tick_reg + 8'd1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_NOTE:
                    begin
                        note_next  = item.rx_byte;
                        phase_next = PH_VEL;
                    end
                    PH_VEL:
                    begin
                        harmony_next = note_reg + mnh_pkg::HARMONY_STEP
                                     + {5'd0, item.harmony_offset};
                        job_push        = 1'b1;
                        job.kind        = mnh_pkg::JOB_CHORD;
                        job.status      = status_reg;
                        job.new_harmony = harmony_next;
                        tick_next       = 8'd0;
                        phase_next      = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if ((item.rx_byte & mnh_pkg::NOTE_ON_MASK)
                            == mnh_pkg::NOTE_ON_CODE)
                        begin
                            status_next = item.rx_byte;
                            phase_next  = PH_NOTE;
                        end
                        else
                        begin
                            job_push = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            status_reg  <= 8'd0;
            note_reg    <= 8'd0;
            harmony_reg <= mnh_pkg::HARMONY_RESET;
            tick_reg    <= 8'd0;
            period_reg  <= mnh_pkg::PERIOD_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            status_reg  <= status_next;
            note_reg    <= note_next;
            harmony_reg <= harmony_next;
            tick_reg    <= tick_next;
            period_reg  <= period_next;
        end
    end

endmodule

@@ design/mnh_queue.sv @@
// ----------------------------------------------------------------------------
// mnh_queue: job queue between front and back
// Small register queue; the head entry is visible without a read cycle.
// ----------------------------------------------------------------------------
module mnh_queue #(
    parameter int DEPTH = mnh_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  mnh_pkg::job_t wr_job,
    input  logic          rd,
    output logic          full,
    output logic          head_valid,
    output mnh_pkg::job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mnh_pkg::job_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (!full || rd))
        else $error("job written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> head_valid)
        else $error("job taken from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/mnh_back.sv @@
// ----------------------------------------------------------------------------
// mnh_back: byte sequencer
// Expands the head job into its byte run, one byte per cycle while the
// output register is free or popped; releases the job with its last byte.
// ----------------------------------------------------------------------------
module mnh_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  mnh_pkg::job_t head,
    input  logic          pop,
    output logic          deq,
    output logic          empty,
    output mnh_pkg::out_t out_item
);

    logic                      out_valid_reg, out_valid_next;
    mnh_pkg::out_t             out_reg,       out_next;
    logic [mnh_pkg::IDX_W-1:0] idx_reg,       idx_next;
    logic                      load;
    mnh_pkg::out_t             cur_byte;

    assign cur_byte = mnh_pkg::job_byte(head, idx_reg);
    assign load     = head_valid && (!out_valid_reg || pop);
    assign deq      = load && cur_byte.last;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = cur_byte;
            idx_next       = cur_byte.last ? '0 : idx_reg + 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= mnh_pkg::CHORD_LAST_IDX)
        else $error("byte index past the longest run");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid)
        else $error("job left the queue in the middle of its run");

    a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        deq |=> (idx_reg == '0))
        else $error("byte index not rewound after a finished run");

endmodule

@@ design/midi_note_harmonizer_core.sv @@
// ----------------------------------------------------------------------------
// midi_note_harmonizer_core: MIDI byte-stream harmonizer with timed release
// Input beats carry a received MIDI byte or a timer tick; output beats carry
// the bytes to transmit, with last marking the end of each job's run.
//
// Usage:
//  - Input side: drive in_item and push; a beat is taken when push is high
//    and full is low. Full rises only while the job queue is full.
//  - Output side: while empty is low, out_item holds the oldest byte; pulse
//    pop to take it. Holding pop low stalls only the byte sequencer; the
//    front keeps taking input beats until the job queue fills.
//  - Configuration: cfg_wr_en with cfg_wr_data writes the release period.
//    Write only while no run is pending.
//  - Path: a taken input beat writes its job into the job queue, and the
//    first byte of the run is then loaded from the queue head into out_item.
//  - Throughput: the output register emits one byte per cycle while pop
//    takes each byte. A captured note-on (three input beats) expands into
//    nine bytes; a pass-through byte expands into one.
//  - Reset: idle capture, harmony note 50, tick count 0, period 30, queue
//    and output register empty.
// ----------------------------------------------------------------------------
module midi_note_harmonizer_core #(
    parameter int QUEUE_DEPTH = mnh_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    // input queue side
    input  logic          push,
    output logic          full,
    input  mnh_pkg::in_t  in_item,
    // result queue side
    output logic          empty,
    input  logic          pop,
    output mnh_pkg::out_t out_item,
    // configuration
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data
);

    logic          accept;
    logic          job_push;
    mnh_pkg::job_t job;
    logic          head_valid;
    mnh_pkg::job_t head;
    logic          deq;
    logic          out_pop;

    // take an input beat whenever the job queue has room
    assign accept  = push && !full;
    // a pop against an empty output register means nothing
    assign out_pop = pop && !empty;

    // Front: classify each beat, update capture and tick state, and emit
    // at most one job (pass-through, release burst or harmonized chord).
    mnh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_push    (job_push),
        .job         (job)
    );

    // Queue: decouple the classifier from the byte sequencer so that a
    // stalled receiver does not hold back input until the queue fills.
    mnh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (job_push),
        .wr_job     (job),
        .rd         (deq),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: walk the head job byte by byte into the output register.
    mnh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (out_pop),
        .deq        (deq),
        .empty      (empty),
        .out_item   (out_item)
    );

endmodule
